/* rtl/scfpm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scfpm_pkg: shared types and constants of the cone filter
// Fixed-point constants, CORDIC arctangent table, item records and register
// indexes used across the proper-motion, reduction, CORDIC and dot stages.
// ----------------------------------------------------------------------------
package scfpm_pkg;

  // Proper motion scale: 2^68 * pi / (180*3600*1000*100*256), rounded down.
  localparam logic [25:0] PM_SCALE = 26'd55895211;
  localparam logic signed [31:0] HALF_PI_Q28    = 32'sd421657428;
  localparam logic signed [31:0] QUARTER_PI_Q28 = 32'sd210828714;
  localparam logic signed [32:0] CORDIC_INV_GAIN = 33'sd652032874;
  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
  localparam int CORDIC_STAGES_DEF = 28;
  localparam int RED_STEPS = 5;

  localparam logic [2:0] CLS_NULL    = 3'd6;
  localparam logic [2:0] CLS_INVALID = 3'd7;
  localparam logic signed [15:0] CLS_COUNT = 16'sd6;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_MIN_COSINE = 3'd3,
    REG_EPOCH      = 3'd4,
    REG_MAG_NULL   = 3'd5,
    REG_CLASS_NULL = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic [31:0]        star_id;
    logic signed [31:0] ra;
    logic signed [31:0] dec;
    logic signed [23:0] ra_motion;
    logic signed [23:0] dec_motion;
    logic signed [15:0] magnitude;
    logic signed [15:0] class_code;
  } star_t;

  typedef struct packed {
    logic [31:0]        star_id;
    logic signed [31:0] ra;
    logic signed [31:0] dec;
    logic signed [15:0] magnitude;
    logic               mag_null;
    logic [2:0]         cls;
  } side_t;

  typedef struct packed {
    side_t              side;
    quad_e              kr;
    quad_e              kd;
    logic signed [32:0] xr;
    logic signed [32:0] yr;
    logic signed [31:0] zr;
    logic signed [32:0] xd;
    logic signed [32:0] yd;
    logic signed [31:0] zd;
  } cord_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
    logic signed [31:0] a;
    case (idx)
      5'd0:  a = 32'sd843314856;
      5'd1:  a = 32'sd497837829;
      5'd2:  a = 32'sd263043836;
      5'd3:  a = 32'sd133525158;
      5'd4:  a = 32'sd67021686;
      5'd5:  a = 32'sd33543515;
      5'd6:  a = 32'sd16775850;
      5'd7:  a = 32'sd8388437;
      5'd8:  a = 32'sd4194282;
      5'd9:  a = 32'sd2097149;
      5'd10: a = 32'sd1048575;
      5'd11: a = 32'sd524287;
      5'd12: a = 32'sd262143;
      5'd13: a = 32'sd131071;
      5'd14: a = 32'sd65535;
      5'd15: a = 32'sd32767;
      5'd16: a = 32'sd16383;
      5'd17: a = 32'sd8191;
      5'd18: a = 32'sd4095;
      5'd19: a = 32'sd2047;
      5'd20: a = 32'sd1023;
      5'd21: a = 32'sd511;
      5'd22: a = 32'sd255;
      5'd23: a = 32'sd127;
      5'd24: a = 32'sd63;
      5'd25: a = 32'sd31;
      5'd26: a = 32'sd15;
      5'd27: a = 32'sd7;
      5'd28: a = 32'sd3;
      5'd29: a = 32'sd1;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

  // Multiple of pi/2 for a quadrant count of -5..5.
  function automatic logic signed [32:0] half_pi_mul(input logic signed [3:0] k);
    logic signed [32:0] v;
    case (k)
      4'sd1:  v = 33'sd421657428;
      4'sd2:  v = 33'sd843314856;
      4'sd3:  v = 33'sd1264972284;
      4'sd4:  v = 33'sd1686629712;
      4'sd5:  v = 33'sd2108287140;
      -4'sd1: v = -33'sd421657428;
      -4'sd2: v = -33'sd843314856;
      -4'sd3: v = -33'sd1264972284;
      -4'sd4: v = -33'sd1686629712;
      -4'sd5: v = -33'sd2108287140;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/scfpm_pm.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scfpm_pm: proper motion correction
// Three stages: motion times epoch, split scale multiply, round and
// saturating add to the catalog angles. Also decodes magnitude and class.
// ----------------------------------------------------------------------------
module scfpm_pm (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire scfpm_pkg::star_t  in_data_i,
  input  wire  signed [19:0]     epoch_i,
  input  wire  signed [15:0]     mag_null_i,
  input  wire  signed [15:0]     class_null_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output scfpm_pkg::side_t       out_data_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  scfpm_pkg::side_t side1_q, side2_q, side3_q, side1_d, side3_d;
  logic signed [43:0] pr1_q, pd1_q;
  logic negr2_q, negd2_q;
  logic [46:0] phr2_q, phd2_q;
  logic [47:0] plr2_q, pld2_q;
  logic [42:0] mr, md;

  function automatic logic signed [30:0] delta(input logic neg, input logic [46:0] ph,
                                               input logic [47:0] pl);
    logic [69:0] tot;
    logic signed [30:0] d;
    tot = (70'(ph) << 22) + 70'(pl) + (70'd1 << 39);
    d = $signed({1'b0, tot[69:40]});
    return neg ? -d : d;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [30:0] d);
    logic signed [32:0] s;
    s = 33'(a) + 33'(d);
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    side1_d.star_id   = in_data_i.star_id;
    side1_d.ra        = in_data_i.ra;
    side1_d.dec       = in_data_i.dec;
    side1_d.magnitude = in_data_i.magnitude;
    side1_d.mag_null  = (mag_null_i != 16'sd0) && (in_data_i.magnitude == mag_null_i);
    if ((class_null_i != 16'sd0) && (in_data_i.class_code == class_null_i)) begin
      side1_d.cls = scfpm_pkg::CLS_NULL;
    end else if (in_data_i.class_code < 16'sd0 ||
                 in_data_i.class_code >= scfpm_pkg::CLS_COUNT) begin
      side1_d.cls = scfpm_pkg::CLS_INVALID;
    end else begin
      side1_d.cls = in_data_i.class_code[2:0];
    end
  end

  assign mr = pr1_q[43] ? 43'(-pr1_q) : 43'(pr1_q);
  assign md = pd1_q[43] ? 43'(-pd1_q) : 43'(pd1_q);

  always_comb begin
    side3_d     = side2_q;
    side3_d.ra  = sat_add(side2_q.ra, delta(negr2_q, phr2_q, plr2_q));
    side3_d.dec = sat_add(side2_q.dec, delta(negd2_q, phd2_q, pld2_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      side1_q <= side1_d;
      pr1_q   <= 44'(in_data_i.ra_motion) * 44'(epoch_i);
      pd1_q   <= 44'(in_data_i.dec_motion) * 44'(epoch_i);
    end
    if (rdy2 && v1_q) begin
      side2_q <= side1_q;
      negr2_q <= pr1_q[43];
      negd2_q <= pd1_q[43];
      phr2_q  <= 47'(mr[42:22]) * 47'(scfpm_pkg::PM_SCALE);
      plr2_q  <= 48'(mr[21:0]) * 48'(scfpm_pkg::PM_SCALE);
      phd2_q  <= 47'(md[42:22]) * 47'(scfpm_pkg::PM_SCALE);
      pld2_q  <= 48'(md[21:0]) * 48'(scfpm_pkg::PM_SCALE);
    end
    if (rdy3 && v2_q) begin
      side3_q <= side3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = side3_q;

endmodule
`default_nettype wire

/* rtl/scfpm_rdc.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scfpm_rdc: quadrant reduction
// Folds both angles into [-pi/4, pi/4] by multiples of pi/2 and seeds the
// CORDIC rotation vectors.
// ----------------------------------------------------------------------------
module scfpm_rdc (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire scfpm_pkg::side_t  in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output scfpm_pkg::cord_t       out_data_o
);

  logic v1_q, v2_q, rdy1, rdy2;
  scfpm_pkg::side_t side1_q;
  logic signed [3:0] kr_d, kd_d, kr1_q, kd1_q;
  scfpm_pkg::cord_t cord_d, cord_q;
  logic signed [32:0] rr, rd;

  function automatic logic signed [3:0] quad_count(input logic signed [31:0] a);
    logic signed [3:0] k;
    logic signed [32:0] thr;
    k = 4'sd0;
    for (int j = 0; j < scfpm_pkg::RED_STEPS; j++) begin
      thr = 33'(scfpm_pkg::QUARTER_PI_Q28) + scfpm_pkg::half_pi_mul(4'(j));
      if (33'(a) > thr) begin
        k = k + 4'sd1;
      end
      if (33'(a) < -thr) begin
        k = k - 4'sd1;
      end
    end
    return k;
  endfunction

  assign rdy2 = !v2_q || out_ready_i;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign kr_d = quad_count(in_data_i.ra);
  assign kd_d = quad_count(in_data_i.dec);
  assign rr = 33'(side1_q.ra) - scfpm_pkg::half_pi_mul(kr1_q);
  assign rd = 33'(side1_q.dec) - scfpm_pkg::half_pi_mul(kd1_q);

  always_comb begin
    cord_d.side = side1_q;
    cord_d.kr   = scfpm_pkg::quad_e'(kr1_q[1:0]);
    cord_d.kd   = scfpm_pkg::quad_e'(kd1_q[1:0]);
    cord_d.xr   = scfpm_pkg::CORDIC_INV_GAIN;
    cord_d.yr   = 33'sd0;
    cord_d.zr   = {rr[29:0], 2'b00};
    cord_d.xd   = scfpm_pkg::CORDIC_INV_GAIN;
    cord_d.yd   = 33'sd0;
    cord_d.zd   = {rd[29:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      side1_q <= in_data_i;
      kr1_q   <= kr_d;
      kd1_q   <= kd_d;
    end
    if (rdy2 && v1_q) begin
      cord_q <= cord_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_data_o  = cord_q;

endmodule
`default_nettype wire

/* rtl/scfpm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scfpm_cell: one CORDIC rotation
// Rotates the right ascension and declination vectors by the arctangent of
// 2^-IDX toward zero residual angle, then passes the item to the next cell.
// ----------------------------------------------------------------------------
module scfpm_cell #(
  parameter int IDX = 0
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire scfpm_pkg::cord_t  in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output scfpm_pkg::cord_t       out_data_o
);

  logic v_q, rdy;
  scfpm_pkg::cord_t cord_d, cord_q;
  logic signed [31:0] atan_c;

  assign atan_c = scfpm_pkg::atan_q30(5'(IDX));
  assign rdy = !v_q || out_ready_i;
  assign in_ready_o = rdy;

  always_comb begin
    cord_d = in_data_i;
    if (in_data_i.zr >= 32'sd0) begin
      cord_d.xr = in_data_i.xr - (in_data_i.yr >>> IDX);
      cord_d.yr = in_data_i.yr + (in_data_i.xr >>> IDX);
      cord_d.zr = in_data_i.zr - atan_c;
    end else begin
      cord_d.xr = in_data_i.xr + (in_data_i.yr >>> IDX);
      cord_d.yr = in_data_i.yr - (in_data_i.xr >>> IDX);
      cord_d.zr = in_data_i.zr + atan_c;
    end
    if (in_data_i.zd >= 32'sd0) begin
      cord_d.xd = in_data_i.xd - (in_data_i.yd >>> IDX);
      cord_d.yd = in_data_i.yd + (in_data_i.xd >>> IDX);
      cord_d.zd = in_data_i.zd - atan_c;
    end else begin
      cord_d.xd = in_data_i.xd + (in_data_i.yd >>> IDX);
      cord_d.yd = in_data_i.yd - (in_data_i.xd >>> IDX);
      cord_d.zd = in_data_i.zd + atan_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      cord_q <= cord_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_data_o  = cord_q;

endmodule
`default_nettype wire

/* rtl/scfpm_dot.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scfpm_dot: unit vector, dot product and cone test
// Clamps and unfolds sine and cosine, forms the unit vector, multiplies it
// with the center vector and keeps the item only if it lies inside the cone.
// ----------------------------------------------------------------------------
module scfpm_dot (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire scfpm_pkg::cord_t  in_data_i,
  input  wire  signed [31:0]     center_x_i,
  input  wire  signed [31:0]     center_y_i,
  input  wire  signed [31:0]     center_z_i,
  input  wire  signed [31:0]     min_cosine_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output scfpm_pkg::side_t       out_data_o
);

  logic va_q, vb_q, vc_q, vd_q;
  logic rdya, rdyb, rdyc, rdyd;
  scfpm_pkg::side_t sa_q, sb_q, sc_q, sd_q;
  logic signed [31:0] cr_d, sr_d, cd_d, sn_d;
  logic signed [31:0] cr_q, sr_q, cd_q, sn_q;
  logic signed [63:0] pxr, pyr;
  logic signed [31:0] x_q, y_q, z_q;
  logic signed [63:0] px_q, py_q, pz_q;
  logic signed [65:0] dot, lim;
  logic pass;

  function automatic logic signed [31:0] clamp1(input logic signed [32:0] v);
    if (v > scfpm_pkg::ONE_Q30) begin
      return 32'(scfpm_pkg::ONE_Q30);
    end else if (v < -scfpm_pkg::ONE_Q30) begin
      return 32'(-scfpm_pkg::ONE_Q30);
    end
    return v[31:0];
  endfunction

  assign rdyd = !vd_q || out_ready_i;
  assign rdyc = !vc_q || rdyd;
  assign rdyb = !vb_q || rdyc;
  assign rdya = !va_q || rdyb;
  assign in_ready_o = rdya;

  always_comb begin
    logic signed [31:0] ccr, ssr, ccd, ssd;
    ccr = clamp1(in_data_i.xr);
    ssr = clamp1(in_data_i.yr);
    ccd = clamp1(in_data_i.xd);
    ssd = clamp1(in_data_i.yd);
    case (in_data_i.kr)
      scfpm_pkg::QUAD_0: begin cr_d = ccr;  sr_d = ssr;  end
      scfpm_pkg::QUAD_1: begin cr_d = -ssr; sr_d = ccr;  end
      scfpm_pkg::QUAD_2: begin cr_d = -ccr; sr_d = -ssr; end
      default:           begin cr_d = ssr;  sr_d = -ccr; end
    endcase
    case (in_data_i.kd)
      scfpm_pkg::QUAD_0: begin cd_d = ccd;  sn_d = ssd;  end
      scfpm_pkg::QUAD_1: begin cd_d = -ssd; sn_d = ccd;  end
      scfpm_pkg::QUAD_2: begin cd_d = -ccd; sn_d = -ssd; end
      default:           begin cd_d = ssd;  sn_d = -ccd; end
    endcase
  end

  // Rounded Q1.30 products; the results stay within one in magnitude.
  assign pxr = 64'(cr_q) * 64'(cd_q) + 64'sd536870912;
  assign pyr = 64'(sr_q) * 64'(cd_q) + 64'sd536870912;

  assign dot  = 66'(px_q) + 66'(py_q) + 66'(pz_q);
  assign lim  = 66'(min_cosine_i) <<< 30;
  assign pass = dot > lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdya) begin
        va_q <= in_valid_i;
      end
      if (rdyb) begin
        vb_q <= va_q;
      end
      if (rdyc) begin
        vc_q <= vb_q;
      end
      if (rdyd) begin
        vd_q <= vc_q && pass;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdya && in_valid_i) begin
      sa_q <= in_data_i.side;
      cr_q <= cr_d;
      sr_q <= sr_d;
      cd_q <= cd_d;
      sn_q <= sn_d;
    end
    if (rdyb && va_q) begin
      sb_q <= sa_q;
      x_q  <= pxr[61:30];
      y_q  <= pyr[61:30];
      z_q  <= sn_q;
    end
    if (rdyc && vb_q) begin
      sc_q <= sb_q;
      px_q <= 64'(center_x_i) * 64'(x_q);
      py_q <= 64'(center_y_i) * 64'(y_q);
      pz_q <= 64'(center_z_i) * 64'(z_q);
    end
    if (rdyd && vc_q) begin
      sd_q <= sc_q;
    end
  end

  assign out_valid_o = vd_q;
  assign out_data_o  = sd_q;

endmodule
`default_nettype wire

/* rtl/sky_cone_filter_proper_motion_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sky_cone_filter_proper_motion_core: cone search with proper motion
// Moves each star by its proper motion, forms its unit vector with a chain
// of CORDIC cells and passes it on only if it lies inside the search cone.
//
//   Channel  Signals                              Direction
//   in       in_valid_i/in_ready_o, star fields   item in
//   out      out_valid_o/out_ready_i, results     zero or one item out
//   cfg      cfg_valid_i/cfg_ready_o, index/data  register write
//
// One item per cycle enters unless a stalled output backs up; the path has
// three proper-motion stages, two reduction stages, one cell per rotation and
// four dot-product stages. Every stage has its own valid bit and fills bubbles,
// so a stalled output only holds the stages behind it once they are full.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module sky_cone_filter_proper_motion_core #(
  parameter int CORDIC_STAGES = scfpm_pkg::CORDIC_STAGES_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [31:0]         star_id_i,
  input  wire  signed [31:0]  ra_angle_i,
  input  wire  signed [31:0]  dec_angle_i,
  input  wire  signed [23:0]  ra_motion_i,
  input  wire  signed [23:0]  dec_motion_i,
  input  wire  signed [15:0]  magnitude_i,
  input  wire  signed [15:0]  class_code_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [31:0]         out_star_id_o,
  output logic signed [31:0]  ra_at_epoch_o,
  output logic signed [31:0]  dec_at_epoch_o,
  output logic signed [15:0]  out_magnitude_o,
  output logic                mag_is_null_o,
  output logic [2:0]          class_result_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [2:0]          cfg_index_i,
  input  wire  [31:0]         cfg_data_i
);

  logic signed [31:0] center_x_q, center_y_q, center_z_q, min_cosine_q;
  logic signed [19:0] epoch_q;
  logic signed [15:0] mag_null_q, class_null_q;

  scfpm_pkg::star_t star;
  logic pm_valid, pm_ready, rd_valid, rd_ready;
  scfpm_pkg::side_t pm_data, res;
  scfpm_pkg::cord_t c_data [0:CORDIC_STAGES];
  logic c_valid [0:CORDIC_STAGES];
  logic c_ready [0:CORDIC_STAGES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= 32'sd1073741824;
      center_y_q   <= 32'sd0;
      center_z_q   <= 32'sd0;
      min_cosine_q <= 32'sd1073741824;
      epoch_q      <= 20'sd0;
      mag_null_q   <= 16'sd0;
      class_null_q <= 16'sd0;
    end else if (cfg_valid_i) begin
      case (scfpm_pkg::cfg_reg_e'(cfg_index_i))
        scfpm_pkg::REG_CENTER_X:   center_x_q   <= cfg_data_i;
        scfpm_pkg::REG_CENTER_Y:   center_y_q   <= cfg_data_i;
        scfpm_pkg::REG_CENTER_Z:   center_z_q   <= cfg_data_i;
        scfpm_pkg::REG_MIN_COSINE: min_cosine_q <= cfg_data_i;
        scfpm_pkg::REG_EPOCH:      epoch_q      <= cfg_data_i[19:0];
        scfpm_pkg::REG_MAG_NULL:   mag_null_q   <= cfg_data_i[15:0];
        scfpm_pkg::REG_CLASS_NULL: class_null_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    star.star_id    = star_id_i;
    star.ra         = ra_angle_i;
    star.dec        = dec_angle_i;
    star.ra_motion  = ra_motion_i;
    star.dec_motion = dec_motion_i;
    star.magnitude  = magnitude_i;
    star.class_code = class_code_i;
  end

  scfpm_pm u_pm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (star),
    .epoch_i      (epoch_q),
    .mag_null_i   (mag_null_q),
    .class_null_i (class_null_q),
    .out_valid_o  (pm_valid),
    .out_ready_i  (pm_ready),
    .out_data_o   (pm_data)
  );

  scfpm_rdc u_rdc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pm_valid),
    .in_ready_o  (pm_ready),
    .in_data_i   (pm_data),
    .out_valid_o (c_valid[0]),
    .out_ready_i (c_ready[0]),
    .out_data_o  (c_data[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    scfpm_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (c_valid[i]),
      .in_ready_o  (c_ready[i]),
      .in_data_i   (c_data[i]),
      .out_valid_o (c_valid[i+1]),
      .out_ready_i (c_ready[i+1]),
      .out_data_o  (c_data[i+1])
    );
  end

  scfpm_dot u_dot (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (c_valid[CORDIC_STAGES]),
    .in_ready_o   (c_ready[CORDIC_STAGES]),
    .in_data_i    (c_data[CORDIC_STAGES]),
    .center_x_i   (center_x_q),
    .center_y_i   (center_y_q),
    .center_z_i   (center_z_q),
    .min_cosine_i (min_cosine_q),
    .out_valid_o  (rd_valid),
    .out_ready_i  (rd_ready),
    .out_data_o   (res)
  );

  assign out_valid_o     = rd_valid;
  assign rd_ready        = out_ready_i;
  assign out_star_id_o   = res.star_id;
  assign ra_at_epoch_o   = res.ra;
  assign dec_at_epoch_o  = res.dec;
  assign out_magnitude_o = res.magnitude;
  assign mag_is_null_o   = res.mag_null;
  assign class_result_o  = res.cls;

  // With the output stage empty every stage behind it can move.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  a_mag_null_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mag_null_q == 16'sd0 && $stable(mag_null_q)) |-> !mag_is_null_o)
    else $error("magnitude marked null with null test disabled");

  a_cls_null_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && class_null_q == 16'sd0 && $stable(class_null_q))
      |-> class_result_o != scfpm_pkg::CLS_NULL)
    else $error("class marked null with null test disabled");

endmodule
`default_nettype wire

/* bench/sky_cone_filter_proper_motion_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sky_cone_filter_proper_motion_core_tb: self-checking bench of the cone filter
// Streams catalog stars through the core under several register settings,
// predicts which stars fall inside the cone and what each emitted item holds,
// and compares every output item field by field in order.
// ----------------------------------------------------------------------------
module sky_cone_filter_proper_motion_core_tb;

  localparam int STAGES   = scfpm_pkg::CORDIC_STAGES_DEF;
  localparam int DRAIN    = STAGES + 30;
  localparam longint HALF = longint'(scfpm_pkg::HALF_PI_Q28);
  localparam longint QTR  = longint'(scfpm_pkg::QUARTER_PI_Q28);
  localparam longint UNIT = 64'sd1073741824;

  localparam longint ARCTAN [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 7, 3, 1, 0, 0};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [31:0] star_id_i = '0;
  logic signed [31:0] ra_angle_i = '0;
  logic signed [31:0] dec_angle_i = '0;
  logic signed [23:0] ra_motion_i = '0;
  logic signed [23:0] dec_motion_i = '0;
  logic signed [15:0] magnitude_i = '0;
  logic signed [15:0] class_code_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [31:0] out_star_id_o;
  logic signed [31:0] ra_at_epoch_o;
  logic signed [31:0] dec_at_epoch_o;
  logic signed [15:0] out_magnitude_o;
  logic mag_is_null_o;
  logic [2:0] class_result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  sky_cone_filter_proper_motion_core DUT (.*);

  always #5 clk_i = ~clk_i;

  // Register copy used by the predictor.
  logic signed [31:0] ctr_x = 32'sd1073741824, ctr_y = '0, ctr_z = '0;
  logic signed [31:0] cos_limit = 32'sd1073741824;
  logic signed [19:0] epoch_ofs = '0;
  logic signed [15:0] mag_mark = '0, cls_mark = '0;

  scfpm_pkg::star_t pending_stars[$];
  scfpm_pkg::side_t expected_hits[$];
  int send_idle_pct = 32, recv_idle_pct = 72;
  logic in_took = 1'b0;
  int n_stars = 0, n_hits = 0, n_errors = 0, n_settings = 0;

  function automatic longint pm_shift(longint motion, longint epoch);
    longint p, d;
    logic [63:0] m, hi, lo, t;
    p = motion * epoch;
    m = (p < 0) ? -p : p;
    hi = m >> 20;
    lo = m & 64'hFFFFF;
    t = hi * 64'(scfpm_pkg::PM_SCALE) +
        ((lo * 64'(scfpm_pkg::PM_SCALE) + (64'd1 << 39)) >> 20);
    d = t >> 20;
    return (p < 0) ? -d : d;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_unit(longint v);
    return (v > UNIT) ? UNIT : ((v < -UNIT) ? -UNIT : v);
  endfunction

  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint r, x, y, z, dx, dy, cc, ss;
    int k;
    r = ang;
    x = 64'sd652032874;
    y = 0;
    k = 0;
    while (r > QTR) begin
      r -= HALF;
      k++;
    end
    while (r < -QTR) begin
      r += HALF;
      k--;
    end
    z = r * 4;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    cc = clamp_unit(x);
    ss = clamp_unit(y);
    case (k & 3)
      0: begin c = cc;  s = ss;  end
      1: begin c = -ss; s = cc;  end
      2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
  endfunction

  // Unit vector of a sky position in Q1.30.
  function automatic void sky_vector(input longint ra, input longint dec,
                                     output longint x, output longint y,
                                     output longint z);
    longint cr, sr, cd, sd;
    sin_cos(ra, cr, sr);
    sin_cos(dec, cd, sd);
    x = (cr * cd + (64'sd1 << 29)) >>> 30;
    y = (sr * cd + (64'sd1 << 29)) >>> 30;
    z = sd;
  endfunction

  // Returns 1 and fills the item when the star falls inside the cone.
  function automatic bit cone_match(input scfpm_pkg::star_t st,
                                    output scfpm_pkg::side_t hit);
    longint ra, dec, x, y, z, dot;
    ra = sat32(longint'(st.ra) + pm_shift(longint'(st.ra_motion), longint'(epoch_ofs)));
    dec = sat32(longint'(st.dec) + pm_shift(longint'(st.dec_motion), longint'(epoch_ofs)));
    sky_vector(ra, dec, x, y, z);
    dot = longint'(ctr_x) * x + longint'(ctr_y) * y + longint'(ctr_z) * z;
    hit = '0;
    if (!(dot > longint'(cos_limit) * UNIT)) return 0;
    hit.star_id = st.star_id;
    hit.ra = ra[31:0];
    hit.dec = dec[31:0];
    hit.magnitude = st.magnitude;
    hit.mag_null = (mag_mark != 16'sd0) && (st.magnitude == mag_mark);
    if (cls_mark != 16'sd0 && st.class_code == cls_mark) hit.cls = scfpm_pkg::CLS_NULL;
    else if (st.class_code < 16'sd0 || st.class_code >= scfpm_pkg::CLS_COUNT)
      hit.cls = scfpm_pkg::CLS_INVALID;
    else hit.cls = st.class_code[2:0];
    return 1;
  endfunction

  // Sender: a new item is offered only once the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (pending_stars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        scfpm_pkg::star_t st;
        st = pending_stars.pop_front();
        in_valid_i   <= 1'b1;
        star_id_i    <= st.star_id;
        ra_angle_i   <= st.ra;
        dec_angle_i  <= st.dec;
        ra_motion_i  <= st.ra_motion;
        dec_motion_i <= st.dec_motion;
        magnitude_i  <= st.magnitude;
        class_code_i <= st.class_code;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    scfpm_pkg::side_t hit, want;
    scfpm_pkg::star_t st;
    in_took <= in_valid_i && in_ready_o;
    if (out_valid_o && out_ready_i) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected item, star_id %h", $time, out_star_id_o);
        n_errors++;
      end else begin
        want = expected_hits.pop_front();
        n_hits++;
        if (out_star_id_o !== want.star_id || ra_at_epoch_o !== want.ra ||
            dec_at_epoch_o !== want.dec || out_magnitude_o !== want.magnitude ||
            mag_is_null_o !== want.mag_null || class_result_o !== want.cls) begin
          $display("%0t: mismatch expected id %h ra %0d dec %0d mag %0d null %b cls %0d",
                   $time, want.star_id, want.ra, want.dec, want.magnitude,
                   want.mag_null, want.cls);
          $display("%0t:          actual   id %h ra %0d dec %0d mag %0d null %b cls %0d",
                   $time, out_star_id_o, ra_at_epoch_o, dec_at_epoch_o,
                   out_magnitude_o, mag_is_null_o, class_result_o);
          n_errors++;
        end
      end
    end
    if (in_valid_i && in_ready_o) begin
      st = '{star_id_i, ra_angle_i, dec_angle_i, ra_motion_i, dec_motion_i,
             magnitude_i, class_code_i};
      n_stars++;
      if (cone_match(st, hit)) expected_hits.push_back(hit);
    end
  end

  task automatic write_reg(input scfpm_pkg::cfg_reg_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      scfpm_pkg::REG_CENTER_X:   ctr_x = data;
      scfpm_pkg::REG_CENTER_Y:   ctr_y = data;
      scfpm_pkg::REG_CENTER_Z:   ctr_z = data;
      scfpm_pkg::REG_MIN_COSINE: cos_limit = data;
      scfpm_pkg::REG_EPOCH:      epoch_ofs = data[19:0];
      scfpm_pkg::REG_MAG_NULL:   mag_mark = data[15:0];
      default:                   cls_mark = data[15:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every item went in and every emitted item came out,
  // then lets the pipeline empty of stars that produce nothing.
  task automatic drain_pipe();
    while (pending_stars.size() > 0 || in_valid_i || expected_hits.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_cone(input longint ra0, input longint dec0,
                          input logic [31:0] limit);
    longint x, y, z;
    sky_vector(ra0, dec0, x, y, z);
    write_reg(scfpm_pkg::REG_CENTER_X, x[31:0]);
    write_reg(scfpm_pkg::REG_CENTER_Y, y[31:0]);
    write_reg(scfpm_pkg::REG_CENTER_Z, z[31:0]);
    write_reg(scfpm_pkg::REG_MIN_COSINE, limit);
    n_settings++;
  endtask

  function automatic logic signed [15:0] pick_class();
    case ($urandom_range(5))
      0: return cls_mark;
      1: return -16'sd1;
      2: return 16'($urandom);
      default: return 16'($urandom_range(7));
    endcase
  endfunction

  function automatic scfpm_pkg::star_t near_star(longint ra0, longint dec0);
    scfpm_pkg::star_t st;
    st.star_id = $urandom;
    st.ra = 32'(ra0 + longint'($signed($urandom_range(0, 1 << 22))) - (1 << 21));
    st.dec = 32'(dec0 + longint'($signed($urandom_range(0, 1 << 22))) - (1 << 21));
    st.ra_motion = 24'($signed($urandom_range(0, 1 << 13)) - (1 << 12));
    st.dec_motion = 24'($signed($urandom_range(0, 1 << 13)) - (1 << 12));
    st.magnitude = ($urandom_range(3) == 0) ? mag_mark : 16'($urandom);
    st.class_code = pick_class();
    return st;
  endfunction

  function automatic scfpm_pkg::star_t noise_star();
    scfpm_pkg::star_t st;
    st = scfpm_pkg::star_t'(176'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom}));
    return st;
  endfunction

  initial begin
    longint ra0, dec0;
    logic [31:0] limit;
    int n_rand;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default registers: the cone is closed, so nothing comes out.
    pending_stars.push_back('{32'h0, 32'sd0, 32'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0});
    pending_stars.push_back('{32'hFFFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                              24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 16'sh8000});
    pending_stars.push_back(noise_star());
    drain_pipe();

    // Open cone, extreme epoch and null marks; the special cases.
    write_reg(scfpm_pkg::REG_MIN_COSINE, 32'hC0000000);
    write_reg(scfpm_pkg::REG_EPOCH, 32'h0007FFFF);
    write_reg(scfpm_pkg::REG_MAG_NULL, 32'h00008000);
    write_reg(scfpm_pkg::REG_CLASS_NULL, 32'h00007FFF);
    n_settings++;
    pending_stars.push_back('{32'h1, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                              24'sh7FFFFF, 24'sh7FFFFF, 16'sh8000, 16'sh7FFF});
    pending_stars.push_back('{32'h2, 32'sh80000000, 32'sh80000000,
                              24'sh800000, 24'sh800000, 16'sh7FFF, 16'sh8000});
    pending_stars.push_back('{32'h3, 32'sd843314856, 32'sd0, 24'sd0, 24'sd0,
                              16'sd0, 16'sd0});
    pending_stars.push_back('{32'h4, -32'sd421657428, 32'sd421657428, 24'sd0,
                              24'sd0, 16'sd1, 16'sd5});
    pending_stars.push_back('{32'h5, 32'sd210828714, -32'sd210828714, 24'sd100,
                              -24'sd100, 16'sd1, 16'sd6});
    for (int c = 0; c < 8; c++)
      pending_stars.push_back('{32'h10 + c, 32'sd1264972284 * c, 32'sd0,
                                24'sd5000, 24'sd0, 16'sd12000, 16'(c)});
    drain_pipe();

    // Negative extreme epoch, out-of-range center and open limit.
    write_reg(scfpm_pkg::REG_EPOCH, 32'h00080000);
    write_reg(scfpm_pkg::REG_CENTER_X, 32'h80000000);
    write_reg(scfpm_pkg::REG_CENTER_Y, 32'h40000000);
    write_reg(scfpm_pkg::REG_CENTER_Z, 32'hC0000000);
    write_reg(scfpm_pkg::REG_MIN_COSINE, 32'h80000000);
    write_reg(scfpm_pkg::REG_MAG_NULL, 32'h00007FFF);
    write_reg(scfpm_pkg::REG_CLASS_NULL, 32'h00008000);
    n_settings++;
    pending_stars.push_back('{32'h20, 32'sd0, 32'sd0, 24'sh7FFFFF, 24'sh800000,
                              16'sh7FFF, 16'sh8000});
    pending_stars.push_back('{32'h21, 32'sh80000000, 32'sh7FFFFFFF, 24'sh7FFFFF,
                              24'sh800000, 16'sd0, 16'sd2});
    drain_pipe();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 32; recv_idle_pct = 72;
      end else if (ph < 6) begin
        send_idle_pct = 72; recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      ra0 = longint'($signed($urandom));
      dec0 = longint'($signed($urandom));
      case ($urandom_range(4))
        0: limit = 32'hC0000000;
        1: limit = 32'h0;
        2: limit = 32'sd1073741824 - $urandom_range(1 << 16);
        3: limit = 32'sd1073741824;
        default: limit = 32'sd1073741824 - $urandom_range(1 << 22);
      endcase
      write_reg(scfpm_pkg::REG_EPOCH, $urandom);
      write_reg(scfpm_pkg::REG_MAG_NULL, ($urandom_range(3) == 0) ? 32'h0 : $urandom);
      write_reg(scfpm_pkg::REG_CLASS_NULL, ($urandom_range(3) == 0) ? 32'h0 : $urandom);
      set_cone(ra0, dec0, limit);
      n_rand = 125;
      for (int i = 0; i < n_rand; i++) begin
        if ($urandom_range(99) < 80) pending_stars.push_back(near_star(ra0, dec0));
        else pending_stars.push_back(noise_star());
      end
      drain_pipe();
    end

    $display("Sent %0d stars under %0d register settings, %0d stars inside the cone.",
             n_stars, n_settings, n_hits);
    if (n_errors == 0 && expected_hits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d items never came out", n_errors, expected_hits.size());
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d items still expected", expected_hits.size());
    $display("FAIL");
    $finish;
  end

endmodule
